// ----- hdl/phcc_pkg.sv -----
// Shared constants and widths for the pitch homing cascade control core.
package phcc_pkg;

  // Block constants
  localparam int SETTLE_TICKS = 1000;
  localparam int LIMIT_MAX    = 4500;
  localparam int LIMIT_STEP   = 4;
  localparam int SNAP_WINDOW  = 50;
  localparam int DEG_SCALE    = 360;
  localparam int HOME_DIV     = 1500;

  // Field widths
  localparam int ENC_W   = 20;
  localparam int GYRO_W  = 16;
  localparam int OFFS_W  = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 14;
  localparam int LIM_W   = 13;
  localparam int TICK_W  = $clog2(SETTLE_TICKS + 2);

  // Config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_TARGET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITION_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY_GAIN = 2'd2;
  localparam logic [GAIN_W-1:0]    POS_GAIN_RESET    = 16'd2048;
  localparam logic [GAIN_W-1:0]    VEL_GAIN_RESET    = 16'd2560;

  // Shared multiplier
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Homing step: |herr| / 1500 as a multiply by a rounded-up reciprocal,
  // exact for magnitudes below 2^20.
  localparam int HOME_SHIFT = 31;
  localparam longint HOME_RECIP = ((64'sd1 <<< HOME_SHIFT) + HOME_DIV - 1) / HOME_DIV;
  localparam int HOME_Q_W = 10;

  // Internal datapath widths
  localparam int HERR_W = ENC_W + 1;
  localparam int DIFF_W = ENC_W + 2;
  localparam int KP_W   = 25;
  localparam int POS_W  = 36;
  localparam int XW     = POS_W + 1;
  localparam int VEL_W  = 34;
  localparam int CPR_SHIFT = 13;
  localparam int VEL_SHIFT = 16;

endpackage

// ----- hdl/pitch_homing_cascade_control_core.sv -----
// Top level of the pitch homing cascade controller: sequencer and datapath.
//
// One control tick per request: encoder count, gyro rate and operator offset in,
// clamped drive and the latched homed flag out. A request runs through a sequencer
// that performs the position gain, the homing step, the position loop and the
// velocity loop one after another through a single shared 32x26 multiplier; the
// next request can be taken once the sequencer is back in idle. in_ready is
// high only while the sequencer is idle. The result sits in an output register,
// so the next request is taken while it waits; the sequencer holds in its last
// step only if a previous result is still untaken. Config writes go straight
// into the registers and can also affect a request already in progress.
module pitch_homing_cascade_control_core
  import phcc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [ENC_W-1:0]    in_encoder_count,
  input  logic signed [GYRO_W-1:0]   in_gyro_rate,
  input  logic signed [OFFS_W-1:0]   in_operator_offset,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [DRIVE_W-1:0]  out_drive,
  output logic                       out_homed,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_KP, S_HMUL, S_HUPD, S_SNAP, S_DIFF,
    S_PMUL, S_POS, S_XSAT, S_VMUL, S_VEL, S_CLAMP
  } state_t;

  state_t state_r;

  // Config registers
  logic signed [ENC_W-1:0] home_target_r;
  logic [GAIN_W-1:0]       position_gain_r;
  logic [GAIN_W-1:0]       velocity_gain_r;

  // Persistent state
  logic [TICK_W-1:0]       tick_r;
  logic                    homed_r;
  logic signed [ENC_W-1:0] sp_r;
  logic [LIM_W-1:0]        lim_r;

  // Per-request working registers
  logic signed [ENC_W-1:0]  enc_r;
  logic signed [GYRO_W-1:0] gyro_r;
  logic signed [OFFS_W-1:0] offs_r;
  logic signed [HERR_W-1:0] herr_r;
  logic [KP_W-1:0]          kp_r;
  logic signed [DIFF_W-1:0] diff_r;
  logic signed [POS_W-1:0]  pos_r;
  logic signed [MUL_A_W-1:0] x_r;
  logic signed [VEL_W-1:0]  vel_r;

  // Output register
  logic                      out_valid_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic                      out_homed_r;

  // Multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;

  phcc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // Accept-time logic
  logic                     accept;
  logic [TICK_W-1:0]        tick_nxt;
  logic                     settle;
  logic [LIM_W:0]           lim_sum;
  logic [LIM_W-1:0]         lim_nxt;
  logic signed [HERR_W-1:0] herr_nxt;

  // Sequencer datapath
  logic [HERR_W-1:0]         herr_mag;
  logic [HOME_Q_W-1:0]       q_mag;
  logic signed [HOME_Q_W:0]  q;
  logic signed [ENC_W:0]     sp_sum;
  logic signed [ENC_W-1:0]   sp_nxt;
  logic signed [ENC_W:0]     snap_d;
  logic [ENC_W:0]            snap_mag;
  logic signed [DIFF_W-1:0]  diff_nxt;
  logic signed [MUL_P_W-1:0] pos_b;
  logic signed [MUL_P_W-1:0] pos_sh;
  logic signed [XW-1:0]      xw;
  logic                      x_ovf;
  logic signed [MUL_A_W-1:0] x_nxt;
  logic signed [MUL_P_W-1:0] vel_b;
  logic signed [MUL_P_W-1:0] vel_sh;
  logic signed [VEL_W-1:0]   lim_pos;
  logic signed [VEL_W-1:0]   lim_neg;
  logic signed [VEL_W-1:0]   clamped;
  logic                      out_free;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    tick_nxt = (tick_r <= TICK_W'(SETTLE_TICKS)) ? tick_r + 1'b1 : tick_r;
    settle   = (tick_nxt <= TICK_W'(SETTLE_TICKS));
    lim_sum  = {1'b0, lim_r} + (LIM_W+1)'(LIMIT_STEP);
    lim_nxt  = (lim_sum > (LIM_W+1)'(LIMIT_MAX)) ? LIM_W'(LIMIT_MAX) : lim_sum[LIM_W-1:0];
    herr_nxt = HERR_W'(home_target_r) - HERR_W'(in_encoder_count);
  end

  always_comb begin
    herr_mag = herr_r[HERR_W-1] ? HERR_W'(-herr_r) : HERR_W'(herr_r);

    // Homing step, truncated toward zero, then saturated to the setpoint range
    q_mag  = mul_p[HOME_SHIFT +: HOME_Q_W];
    q      = herr_r[HERR_W-1] ? -signed'({1'b0, q_mag}) : signed'({1'b0, q_mag});
    sp_sum = (ENC_W+1)'(sp_r) + (ENC_W+1)'(q);
    if (sp_sum[ENC_W] != sp_sum[ENC_W-1]) begin
      sp_nxt = sp_sum[ENC_W] ? {1'b1, {(ENC_W-1){1'b0}}} : {1'b0, {(ENC_W-1){1'b1}}};
    end else begin
      sp_nxt = sp_sum[ENC_W-1:0];
    end

    snap_d   = (ENC_W+1)'(sp_r) - (ENC_W+1)'(home_target_r);
    snap_mag = snap_d[ENC_W] ? (ENC_W+1)'(-snap_d) : (ENC_W+1)'(snap_d);

    diff_nxt = DIFF_W'(enc_r) - DIFF_W'(sp_r) + DIFF_W'(offs_r);

    // Divide by 8192 toward zero
    pos_b  = mul_p + (mul_p[MUL_P_W-1] ? MUL_P_W'((1 << CPR_SHIFT) - 1) : '0);
    pos_sh = pos_b >>> CPR_SHIFT;

    // Saturate to 32 bits; beyond that the clamp decides the drive anyway
    xw    = XW'(pos_r) - (XW'(gyro_r) <<< 8);
    x_ovf = !((&xw[XW-1:MUL_A_W-1]) || !(|xw[XW-1:MUL_A_W-1]));
    if (x_ovf) begin
      x_nxt = xw[XW-1] ? {1'b1, {(MUL_A_W-1){1'b0}}} : {1'b0, {(MUL_A_W-1){1'b1}}};
    end else begin
      x_nxt = xw[MUL_A_W-1:0];
    end

    // Divide by 65536 toward zero
    vel_b  = mul_p + (mul_p[MUL_P_W-1] ? MUL_P_W'((1 << VEL_SHIFT) - 1) : '0);
    vel_sh = vel_b >>> VEL_SHIFT;

    lim_pos = VEL_W'(lim_r);
    lim_neg = -lim_pos;
    if (vel_r > lim_pos) begin
      clamped = lim_pos;
    end else if (vel_r < lim_neg) begin
      clamped = lim_neg;
    end else begin
      clamped = vel_r;
    end
  end

  // Multiplier operand select
  always_comb begin
    case (state_r)
      S_KP: begin
        mul_a = MUL_A_W'(position_gain_r);
        mul_b = MUL_B_W'(DEG_SCALE);
      end
      S_HMUL: begin
        mul_a = MUL_A_W'(herr_mag);
        mul_b = MUL_B_W'(HOME_RECIP);
      end
      S_PMUL: begin
        mul_a = MUL_A_W'(diff_r);
        mul_b = MUL_B_W'(kp_r);
      end
      S_VMUL: begin
        mul_a = x_r;
        mul_b = MUL_B_W'(velocity_gain_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_target_r   <= '0;
      position_gain_r <= POS_GAIN_RESET;
      velocity_gain_r <= VEL_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOME_TARGET:   home_target_r   <= cfg_wdata[ENC_W-1:0];
        REG_POSITION_GAIN: position_gain_r <= cfg_wdata[GAIN_W-1:0];
        REG_VELOCITY_GAIN: velocity_gain_r <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tick_r      <= '0;
      homed_r     <= 1'b0;
      sp_r        <= '0;
      lim_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in the last step the output register is reloaded instead
      if (out_valid_r && out_ready && state_r != S_CLAMP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            tick_r <= tick_nxt;
            lim_r  <= lim_nxt;
            enc_r  <= in_encoder_count;
            gyro_r <= in_gyro_rate;
            offs_r <= settle ? '0 : in_operator_offset;
            herr_r <= herr_nxt;
            if (settle) begin
              sp_r <= in_encoder_count;
            end
            state_r <= S_KP;
          end
        end
        S_KP: state_r <= S_HMUL;
        S_HMUL: begin
          kp_r    <= mul_p[KP_W-1:0];
          state_r <= S_HUPD;
        end
        S_HUPD: begin
          if (!homed_r) begin
            sp_r <= sp_nxt;
          end
          state_r <= S_SNAP;
        end
        S_SNAP: begin
          if (!homed_r && (snap_mag < (ENC_W+1)'(SNAP_WINDOW))) begin
            sp_r    <= home_target_r;
            homed_r <= 1'b1;
          end
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= diff_nxt;
          state_r <= S_PMUL;
        end
        S_PMUL: state_r <= S_POS;
        S_POS: begin
          pos_r   <= pos_sh[POS_W-1:0];
          state_r <= S_XSAT;
        end
        S_XSAT: begin
          x_r     <= x_nxt;
          state_r <= S_VMUL;
        end
        S_VMUL: state_r <= S_VEL;
        S_VEL: begin
          vel_r   <= vel_sh[VEL_W-1:0];
          state_r <= S_CLAMP;
        end
        S_CLAMP: begin
          if (out_free) begin
            out_drive_r <= clamped[DRIVE_W-1:0];
            out_homed_r <= homed_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;
  assign out_homed = out_homed_r;

endmodule

// ----- hdl/phcc_mul.sv -----
// Shared signed multiplier with a registered product.
module phcc_mul
  import phcc_pkg::*;
(
  input  logic                       clk,
  input  logic signed [MUL_A_W-1:0]  mul_a,
  input  logic signed [MUL_B_W-1:0]  mul_b,
  output logic signed [MUL_P_W-1:0]  mul_p
);

  logic signed [MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
  end

  assign mul_p = prod_r;

endmodule
